// ===== src/assert_macros.svh =====
// Assertion macros shared by the corner finder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/bdcf_pkg.sv =====
// Types and constants of the diagonal corner finder.
package bdcf_pkg;
	localparam int COORD_W = 12;
	localparam int LABEL_W = 8;
	localparam int MAX_DIM = 4096;
	localparam int NUM_CORNERS = 4;
	localparam int CIDX_W = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam logic [LABEL_W-1:0] TARGET_RESET = LABEL_W'(1);

	localparam logic [CIDX_W-1:0] CORNER_MIN_SUM  = 2'd0;
	localparam logic [CIDX_W-1:0] CORNER_MAX_DIFF = 2'd1;
	localparam logic [CIDX_W-1:0] CORNER_MAX_SUM  = 2'd2;
	localparam logic [CIDX_W-1:0] CORNER_MIN_DIFF = 2'd3;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               hit;
		logic               last;
	} entry_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} corner_t;

	typedef struct packed {
		logic   push;
		entry_t data;
	} qwrite_t;
endpackage

// ===== src/bdcf_front.sv =====
// Front end: input register, label and bounds classification, queue push.
module bdcf_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bdcf_pkg::LABEL_W-1:0]  cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bdcf_pkg::COORD_W-1:0]  pixel_x,
	input  logic [bdcf_pkg::COORD_W-1:0]  pixel_y,
	input  logic [bdcf_pkg::LABEL_W-1:0]  pixel_label,
	input  logic                          box_end,
	input  logic                          q_full,
	output bdcf_pkg::qwrite_t             qwr
);
	localparam logic [bdcf_pkg::COORD_W:0] DIM_LIMIT = (bdcf_pkg::COORD_W+1)'(bdcf_pkg::MAX_DIM);

	logic [bdcf_pkg::LABEL_W-1:0] target_q;
	logic                         v_s1;
	bdcf_pkg::entry_t             entry_s1;
	bdcf_pkg::entry_t             entry_in;
	logic                         take;
	logic                         push;

	always_comb begin
		entry_in.x    = pixel_x;
		entry_in.y    = pixel_y;
		entry_in.hit  = (pixel_label == target_q) && ({1'b0, pixel_x} < DIM_LIMIT)
			&& ({1'b0, pixel_y} < DIM_LIMIT);
		entry_in.last = box_end;
	end

	assign push     = v_s1 && !q_full;
	assign in_stall = v_s1 && q_full;
	assign take     = in_valid && !in_stall;
	assign qwr      = '{push: push, data: entry_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= bdcf_pkg::TARGET_RESET;
			v_s1     <= 1'b0;
		end else begin
			if (cfg_we) begin
				target_q <= cfg_wdata;
			end
			if (take) begin
				v_s1 <= 1'b1;
			end else if (push) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			entry_s1 <= entry_in;
		end
	end
endmodule

// ===== src/bdcf_queue.sv =====
// Short queue of classified items between front and back.
`include "assert_macros.svh"
module bdcf_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  bdcf_pkg::qwrite_t qwr,
	output logic              full,
	output logic              not_empty,
	output bdcf_pkg::entry_t  head,
	input  logic              pop
);
	localparam logic [bdcf_pkg::QCNT_W-1:0] DEPTH_C = bdcf_pkg::QCNT_W'(bdcf_pkg::QUEUE_DEPTH);

	bdcf_pkg::entry_t              mem_q [bdcf_pkg::QUEUE_DEPTH];
	logic [bdcf_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [bdcf_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [bdcf_pkg::QCNT_W-1:0]   count_q;

	assign full      = (count_q == DEPTH_C);
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (qwr.push) begin
			mem_q[wr_ptr_q] <= qwr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (qwr.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (qwr.push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !qwr.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_IMPLIES(a_count_bound, clk, arst_n, 1'b1, count_q <= DEPTH_C)
	`ASSERT_IMPLIES(a_no_pop_empty, clk, arst_n, pop, count_q != '0)
	`ASSERT_IMPLIES(a_no_push_full, clk, arst_n, qwr.push, !full || pop)
endmodule

// ===== src/bdcf_back.sv =====
// Back end: running corner compare and update, result snapshot and emission.
`include "assert_macros.svh"
module bdcf_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          not_empty,
	input  bdcf_pkg::entry_t              head,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bdcf_pkg::CIDX_W-1:0]   corner_index,
	output logic [bdcf_pkg::COORD_W-1:0]  corner_x,
	output logic [bdcf_pkg::COORD_W-1:0]  corner_y,
	output logic                          region_found,
	output logic                          run_last
);
	localparam logic [bdcf_pkg::CIDX_W-1:0] LAST_IDX = bdcf_pkg::CIDX_W'(bdcf_pkg::NUM_CORNERS - 1);

	bdcf_pkg::corner_t             corner_q [bdcf_pkg::NUM_CORNERS];
	bdcf_pkg::corner_t             corner_nx [bdcf_pkg::NUM_CORNERS];
	bdcf_pkg::corner_t             res_q [bdcf_pkg::NUM_CORNERS];
	logic                          found_q;
	logic                          found_nx;
	logic                          res_found_q;
	logic                          busy_q;
	logic [bdcf_pkg::CIDX_W-1:0]   idx_q;
	logic                          out_take;
	logic                          finishing;

	assign out_valid = busy_q;
	assign out_take  = busy_q && !out_stall;
	assign finishing = out_take && (idx_q == LAST_IDX);
	// a box end waits until the result buffer is free
	assign pop = not_empty && (!head.last || !busy_q || finishing);

	assign corner_index = idx_q;
	assign corner_x     = res_q[idx_q].x;
	assign corner_y     = res_q[idx_q].y;
	assign region_found = res_found_q;
	assign run_last     = (idx_q == LAST_IDX);

	always_comb begin
		logic [bdcf_pkg::COORD_W:0] s_new, s_old, d_new, d_old;
		logic                       tie_x, better;
		s_new  = '0;
		s_old  = '0;
		d_new  = '0;
		d_old  = '0;
		tie_x  = 1'b0;
		better = 1'b0;
		for (int i = 0; i < bdcf_pkg::NUM_CORNERS; i++) begin
			corner_nx[i] = corner_q[i];
		end
		found_nx = found_q;
		if (pop && head.hit) begin
			found_nx = 1'b1;
			for (int i = 0; i < bdcf_pkg::NUM_CORNERS; i++) begin
				// x-y orderings compared as x+oy against ox+y to stay unsigned
				s_new = {1'b0, head.x} + {1'b0, head.y};
				s_old = {1'b0, corner_q[i].x} + {1'b0, corner_q[i].y};
				d_new = {1'b0, head.x} + {1'b0, corner_q[i].y};
				d_old = {1'b0, corner_q[i].x} + {1'b0, head.y};
				tie_x = head.x < corner_q[i].x;
				case (bdcf_pkg::CIDX_W'(i))
					bdcf_pkg::CORNER_MIN_SUM: begin
						better = (s_new < s_old) || ((s_new == s_old) && tie_x);
					end
					bdcf_pkg::CORNER_MAX_DIFF: begin
						better = (d_new > d_old) || ((d_new == d_old) && tie_x);
					end
					bdcf_pkg::CORNER_MAX_SUM: begin
						better = (s_new > s_old) || ((s_new == s_old) && tie_x);
					end
					default: begin
						better = (d_new < d_old) || ((d_new == d_old) && tie_x);
					end
				endcase
				if (better || !found_q) begin
					corner_nx[i].x = head.x;
					corner_nx[i].y = head.y;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bdcf_pkg::NUM_CORNERS; i++) begin
				corner_q[i] <= '0;
			end
			found_q <= 1'b0;
			busy_q  <= 1'b0;
			idx_q   <= '0;
		end else begin
			// a new snapshot takes over the result side, even as the last result leaves
			if (pop && head.last) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (out_take) begin
				idx_q <= idx_q + 1'b1;
				if (finishing) begin
					busy_q <= 1'b0;
				end
			end
			if (pop) begin
				if (head.last) begin
					for (int i = 0; i < bdcf_pkg::NUM_CORNERS; i++) begin
						corner_q[i] <= '0;
					end
					found_q <= 1'b0;
				end else begin
					for (int i = 0; i < bdcf_pkg::NUM_CORNERS; i++) begin
						corner_q[i] <= corner_nx[i];
					end
					found_q <= found_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			for (int i = 0; i < bdcf_pkg::NUM_CORNERS; i++) begin
				res_q[i] <= corner_nx[i];
			end
			res_found_q <= found_nx;
		end
	end

	`ASSERT_IMPLIES(a_idle_idx, clk, arst_n, !busy_q, idx_q == '0)
	`ASSERT_NEXT(a_hold_stalled, clk, arst_n, busy_q && out_stall, busy_q && (idx_q == $past(idx_q)))
	`ASSERT_IMPLIES(a_last_free, clk, arst_n, pop && head.last, !busy_q || finishing)
	`ASSERT_NEXT(a_found_cleared, clk, arst_n, pop && head.last, !found_q)
endmodule

// ===== src/blob_diagonal_corner_finder_unit.sv =====
// Top level of the diagonal corner finder: front, queue and back.
//
// channel  dir  handshake           payload
// in       in   in_valid/in_stall   pixel_x, pixel_y, pixel_label, box_end
// out      out  out_valid/out_stall corner_index, corner_x, corner_y, region_found, run_last
// cfg      in   cfg_we              cfg_wdata (target_label)
//
// One pixel per cycle unless stalled; pixels pass input register and queue to the corner regs.
// A box end yields four results from a snapshot buffer, one per cycle unless out_stall holds;
// the next box streams in meanwhile, and only a second box end waits for that buffer to drain.
// Reset: target label 1, corners and match flag cleared, queue empty.
// out_stall backs up through the 4-entry queue; in_stall rises only when it is full.
module blob_diagonal_corner_finder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bdcf_pkg::LABEL_W-1:0]  cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bdcf_pkg::COORD_W-1:0]  pixel_x,
	input  logic [bdcf_pkg::COORD_W-1:0]  pixel_y,
	input  logic [bdcf_pkg::LABEL_W-1:0]  pixel_label,
	input  logic                          box_end,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bdcf_pkg::CIDX_W-1:0]   corner_index,
	output logic [bdcf_pkg::COORD_W-1:0]  corner_x,
	output logic [bdcf_pkg::COORD_W-1:0]  corner_y,
	output logic                          region_found,
	output logic                          run_last
);
	bdcf_pkg::qwrite_t qwr;
	bdcf_pkg::entry_t  head;
	logic              q_full;
	logic              q_not_empty;
	logic              q_pop;

	bdcf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_label (pixel_label),
		.box_end     (box_end),
		.q_full      (q_full),
		.qwr         (qwr)
	);

	bdcf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.qwr       (qwr),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head),
		.pop       (q_pop)
	);

	bdcf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.not_empty    (q_not_empty),
		.head         (head),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.corner_index (corner_index),
		.corner_x     (corner_x),
		.corner_y     (corner_y),
		.region_found (region_found),
		.run_last     (run_last)
	);
endmodule
